### rtl/rmh_pkg.sv
// rmh_pkg: shared types, sizes and the heap order function for the running
// median block. No dependencies.
package rmh_pkg;

  localparam int CAPACITY   = 1024;
  localparam int HEAP_DEPTH = CAPACITY / 2 + 2;
  localparam int ADDR_W     = $clog2(HEAP_DEPTH);
  localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
  localparam int CH_W       = CNT_W + 1;
  localparam int SAMPLE_W   = 32;
  localparam int MEDIAN_W   = 33;
  localparam int HELD_W     = 11;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [MEDIAN_W-1:0] median_t;
  typedef logic [HELD_W-1:0]          held_t;
  typedef logic [CNT_W-1:0]           cnt_t;

  // True when a sits above b: larger for the max-heap, smaller for the min-heap.
  function automatic logic above(input logic is_max, input sample_t a, input sample_t b);
    above = is_max ? (a > b) : (a < b);
  endfunction

endpackage

### rtl/rmh_in_if.sv
// rmh_in_if: sample channel, valid/ready with one sample per word.
// Depends on rmh_pkg.
interface rmh_in_if;
  import rmh_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

### rtl/rmh_out_if.sv
// rmh_out_if: result channel, valid/ready with median, count and drop flag.
// Depends on rmh_pkg.
interface rmh_out_if;
  import rmh_pkg::*;
  logic    valid;
  logic    ready;
  median_t median_twice;
  held_t   sample_count;
  logic    dropped;
  modport source (output valid, output median_twice, output sample_count,
                  output dropped, input ready);
  modport sink   (input valid, input median_twice, input sample_count,
                  input dropped, output ready);
endinterface

### rtl/running_median_two_heaps.sv
// running_median_two_heaps: running median over two heaps held in RAM.
// Depends on rmh_pkg, rmh_in_if, rmh_out_if and rmh_ram.
//
//   channel | dir | word
//   in_s    | in  | sample (signed 32)
//   out_s   | out | median_twice (signed 33), sample_count (11), dropped (1)
//
// A sample passes through up to four sifts of up to nine levels each; a full store
// skips them and goes straight to the output state. Each sift level works through the
// one read port of the heap RAM being worked on.
// Reset clears both counts; heap RAM contents need no clearing.
// A finished word waits in the output register; a stalled out_s holds the next
// sample in its final state until the register frees.
module running_median_two_heaps (
  input  logic       clk,
  input  logic       rst_n,
  rmh_in_if.sink     in_s,
  rmh_out_if.source  out_s
);
  import rmh_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_A      = 4'd1;
  localparam logic [3:0] S_B      = 4'd2;
  localparam logic [3:0] S_C      = 4'd3;
  localparam logic [3:0] S_C_RD   = 4'd4;
  localparam logic [3:0] S_C_WT   = 4'd5;
  localparam logic [3:0] S_C2     = 4'd6;
  localparam logic [3:0] S_SU_RD  = 4'd7;
  localparam logic [3:0] S_SU_CMP = 4'd8;
  localparam logic [3:0] S_SD_L   = 4'd9;
  localparam logic [3:0] S_SD_R   = 4'd10;
  localparam logic [3:0] S_SD_CMP = 4'd11;
  localparam logic [3:0] S_OUT    = 4'd12;

  // what follows the current sift
  localparam logic [1:0] PH_A = 2'd0;   // lower root replaced
  localparam logic [1:0] PH_B = 2'd1;   // pushed onto upper
  localparam logic [1:0] PH_C = 2'd2;   // upper root popped
  localparam logic [1:0] PH_D = 2'd3;   // pushed back onto lower

  logic [3:0] state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic       sel_r, sel_nxt;          // 1: lower (max) heap, 0: upper (min) heap
  cnt_t       idx_r, idx_nxt;
  cnt_t       n_r, n_nxt;
  sample_t    val_r, val_nxt;
  sample_t    cval_r, cval_nxt;
  sample_t    moved_r, moved_nxt;
  cnt_t       lcnt_r, lcnt_nxt;
  cnt_t       ucnt_r, ucnt_nxt;
  sample_t    ltop_r, ltop_nxt;
  sample_t    utop_r, utop_nxt;
  logic       drop_r, drop_nxt;
  logic       out_valid_r, out_valid_nxt;
  median_t    out_med_r, out_med_nxt;
  held_t      out_cnt_r, out_cnt_nxt;
  logic       out_drop_r, out_drop_nxt;

  logic              wr_en;
  sample_t           wr_data;
  logic [ADDR_W-1:0] raddr;
  sample_t           lo_rdata, up_rdata, rdata;
  logic [CH_W-1:0]   lch, rch;
  cnt_t              par;
  held_t             held;
  median_t           median;
  sample_t           best;
  cnt_t              best_idx;
  logic              sift_done;

  assign rdata    = sel_r ? lo_rdata : up_rdata;
  assign lch      = {idx_r, 1'b1};
  assign rch      = lch + CH_W'(1);
  assign par      = CNT_W'((idx_r - CNT_W'(1)) >> 1);
  assign held     = held_t'(lcnt_r) + held_t'(ucnt_r);
  assign median   = (lcnt_r > ucnt_r) ? {ltop_r, 1'b0}
                                      : {ltop_r[SAMPLE_W-1], ltop_r} + {utop_r[SAMPLE_W-1], utop_r};

  assign in_s.ready         = (state_r == S_IDLE);
  assign out_s.valid        = out_valid_r;
  assign out_s.median_twice = out_med_r;
  assign out_s.sample_count = out_cnt_r;
  assign out_s.dropped      = out_drop_r;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    sel_nxt       = sel_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    val_nxt       = val_r;
    cval_nxt      = cval_r;
    moved_nxt     = moved_r;
    lcnt_nxt      = lcnt_r;
    ucnt_nxt      = ucnt_r;
    ltop_nxt      = ltop_r;
    utop_nxt      = utop_r;
    drop_nxt      = drop_r;
    out_valid_nxt = out_valid_r;
    out_med_nxt   = out_med_r;
    out_cnt_nxt   = out_cnt_r;
    out_drop_nxt  = out_drop_r;
    wr_en         = 1'b0;
    wr_data       = val_r;
    raddr         = '0;
    sift_done     = 1'b0;
    best          = rdata;
    best_idx      = CNT_W'(lch);

    if (out_valid_r && out_s.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_s.valid) begin
          val_nxt = in_s.sample;
          if (held >= held_t'(CAPACITY)) begin
            drop_nxt  = 1'b1;
            state_nxt = S_OUT;
          end else begin
            drop_nxt  = 1'b0;
            state_nxt = S_A;
          end
        end
      end
      S_A: begin
        // push then pop the max: the sample itself leaves unless the top beats it
        if (lcnt_r != '0 && above(1'b1, ltop_r, val_r)) begin
          moved_nxt = ltop_r;
          sel_nxt   = 1'b1;
          idx_nxt   = '0;
          n_nxt     = lcnt_r;
          phase_nxt = PH_A;
          state_nxt = S_SD_L;
        end else begin
          moved_nxt = val_r;
          state_nxt = S_B;
        end
      end
      S_B: begin
        sel_nxt   = 1'b0;
        val_nxt   = moved_r;
        idx_nxt   = ucnt_r;
        ucnt_nxt  = ucnt_r + CNT_W'(1);
        phase_nxt = PH_B;
        state_nxt = S_SU_RD;
      end
      S_C: begin
        if (ucnt_r > lcnt_r) begin
          moved_nxt = utop_r;
          ucnt_nxt  = ucnt_r - CNT_W'(1);
          state_nxt = (ucnt_r == CNT_W'(1)) ? S_C2 : S_C_RD;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_C_RD: begin
        // fetch the last upper entry to refill the root
        sel_nxt   = 1'b0;
        raddr     = ucnt_r[ADDR_W-1:0];
        state_nxt = S_C_WT;
      end
      S_C_WT: begin
        val_nxt   = up_rdata;
        idx_nxt   = '0;
        n_nxt     = ucnt_r;
        phase_nxt = PH_C;
        state_nxt = S_SD_L;
      end
      S_C2: begin
        sel_nxt   = 1'b1;
        val_nxt   = moved_r;
        idx_nxt   = lcnt_r;
        lcnt_nxt  = lcnt_r + CNT_W'(1);
        phase_nxt = PH_D;
        state_nxt = S_SU_RD;
      end
      S_SU_RD: begin
        if (idx_r == '0) begin
          wr_en     = 1'b1;
          sift_done = 1'b1;
        end else begin
          raddr     = par[ADDR_W-1:0];
          state_nxt = S_SU_CMP;
        end
      end
      S_SU_CMP: begin
        wr_en = 1'b1;
        if (above(sel_r, val_r, rdata)) begin
          // pull the parent down into the hole and climb
          wr_data   = rdata;
          idx_nxt   = par;
          state_nxt = S_SU_RD;
        end else begin
          sift_done = 1'b1;
        end
      end
      S_SD_L: begin
        if (lch >= CH_W'(n_r)) begin
          wr_en     = 1'b1;
          sift_done = 1'b1;
        end else begin
          raddr     = lch[ADDR_W-1:0];
          state_nxt = S_SD_R;
        end
      end
      S_SD_R, S_SD_CMP: begin
        if (state_r == S_SD_R && rch < CH_W'(n_r)) begin
          cval_nxt  = rdata;
          raddr     = rch[ADDR_W-1:0];
          state_nxt = S_SD_CMP;
        end else begin
          if (state_r == S_SD_CMP) begin
            if (above(sel_r, rdata, cval_r)) begin
              best     = rdata;
              best_idx = CNT_W'(rch);
            end else begin
              best     = cval_r;
              best_idx = CNT_W'(lch);
            end
          end
          wr_en = 1'b1;
          if (above(sel_r, best, val_r)) begin
            // lift the better child into the hole and descend
            wr_data   = best;
            idx_nxt   = best_idx;
            state_nxt = S_SD_L;
          end else begin
            sift_done = 1'b1;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_s.ready) begin
          out_valid_nxt = 1'b1;
          out_med_nxt   = median;
          out_cnt_nxt   = held;
          out_drop_nxt  = drop_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (sift_done) begin
      case (phase_r)
        PH_A:    state_nxt = S_B;
        PH_B:    state_nxt = S_C;
        PH_C:    state_nxt = S_C2;
        PH_D:    state_nxt = S_OUT;
        default: state_nxt = S_OUT;
      endcase
    end

    // mirror root writes into the top registers
    if (wr_en && idx_r == '0) begin
      if (sel_r) begin
        ltop_nxt = wr_data;
      end else begin
        utop_nxt = wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_A;
      lcnt_r      <= '0;
      ucnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      lcnt_r      <= lcnt_nxt;
      ucnt_r      <= ucnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_r      <= sel_nxt;
    idx_r      <= idx_nxt;
    n_r        <= n_nxt;
    val_r      <= val_nxt;
    cval_r     <= cval_nxt;
    moved_r    <= moved_nxt;
    ltop_r     <= ltop_nxt;
    utop_r     <= utop_nxt;
    drop_r     <= drop_nxt;
    out_med_r  <= out_med_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_drop_r <= out_drop_nxt;
  end

  rmh_ram #(.WIDTH(SAMPLE_W), .DEPTH(HEAP_DEPTH)) u_lower_ram (
    .clk   (clk),
    .we    (wr_en && sel_r),
    .waddr (idx_r[ADDR_W-1:0]),
    .wdata (wr_data),
    .raddr (raddr),
    .rdata (lo_rdata)
  );

  rmh_ram #(.WIDTH(SAMPLE_W), .DEPTH(HEAP_DEPTH)) u_upper_ram (
    .clk   (clk),
    .we    (wr_en && !sel_r),
    .waddr (idx_r[ADDR_W-1:0]),
    .wdata (wr_data),
    .raddr (raddr),
    .rdata (up_rdata)
  );

`ifndef SYNTHESIS
  a_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (lcnt_r == ucnt_r || lcnt_r == ucnt_r + CNT_W'(1)))
    else $error("heap counts out of balance");

  a_held_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (held <= held_t'(CAPACITY)))
    else $error("held count beyond capacity");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_OUT) |-> !wr_en)
    else $error("heap write outside a sift");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_s.valid && in_s.ready) |=> (state_r != S_IDLE))
    else $error("accepted sample not taken up");
`endif

endmodule

### rtl/rmh_ram.sv
// rmh_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
module rmh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
